@@ hw/rtl/mvs_pkg.sv @@
// Package for the mean / variance / standard deviation unit.
// Holds the sizing constants and the beat structs; no dependencies.
package mvs_pkg;

	localparam int MAX_SAMPLES = 256;
	localparam int SAMPLE_BITS = 13;

	localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
	localparam int VAR_W  = 2 * SAMPLE_BITS;
	localparam int SQ_W   = VAR_W + ADDR_W;
	localparam int DCNT_W = $clog2(SQ_W + 1);

	localparam logic [VAR_W-1:0] SQRT_BIT0 = {2'b01, {(VAR_W-2){1'b0}}};

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   is_last;
	} mvs_in_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] mean;
		logic [VAR_W-1:0]       variance;
		logic [SAMPLE_BITS-1:0] std_dev;
		logic [CNT_W-1:0]       sample_count;
		logic                   overflow;
	} mvs_out_t;

endpackage

@@ hw/rtl/mean_variance_stddev_unit.sv @@
// Mean, population variance and standard deviation over a buffered sample set.
// Busy: a sample without is_last leaves busy low; the last sample of a set keeps
// busy high through the mean divide, square pass, variance divide and root,
// which use the shared bit-serial divider and the bit-serial root.
// Throughput: one beat per cycle while loading; the receiver cannot stall.
// Reset: arst_n clears count, sum, drop flag and sequencer; buffer is not cleared.
module mean_variance_stddev_unit
	import mvs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  mvs_in_t  item,
	output logic     busy,
	output logic     done,
	output mvs_out_t result
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_DIV_MEAN = 5'b00010,
		S_SQ       = 5'b00100,
		S_DIV_VAR  = 5'b01000,
		S_SQRT     = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   drop_q;
	logic [DCNT_W-1:0]      div_cnt_q;
	logic [ADDR_W-1:0]      addr_q;
	logic                   issue_q;
	logic                   v_s1;
	logic                   v_s2;
	logic                   done_q;

	logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
	logic [SAMPLE_BITS-1:0] rd_s1;
	logic [VAR_W-1:0]       prod_s2;
	logic [SQ_W-1:0]        acc_q;
	logic [SQ_W-1:0]        dvd_q;
	logic [CNT_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] mean_q;
	logic [VAR_W-1:0]       var_q;
	logic [VAR_W-1:0]       sqv_q;
	logic [VAR_W-1:0]       root_q;
	logic [VAR_W-1:0]       bit_q;
	mvs_out_t               result_q;

	logic                   accept;
	logic                   full;
	logic [SUM_W-1:0]       sum_nxt;
	logic [CNT_W:0]         div_shift;
	logic [CNT_W:0]         div_sub;
	logic                   div_ge;
	logic [CNT_W-1:0]       rem_nxt;
	logic [SQ_W-1:0]        quo_nxt;
	logic                   div_last;
	logic                   issue_last;
	logic                   sq_drained;
	logic [SAMPLE_BITS-1:0] dev;
	logic [VAR_W-1:0]       trial;
	logic                   sqrt_ge;
	logic [VAR_W-1:0]       root_nxt;
	logic [VAR_W-1:0]       sqv_nxt;
	logic                   sqrt_last;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(MAX_SAMPLES));
	assign sum_nxt = full ? sum_q : sum_q + SUM_W'(item.sample);

	// shared restoring divider, one quotient bit a cycle
	assign div_shift = {rem_q, dvd_q[SQ_W-1]};
	assign div_sub   = div_shift - {1'b0, count_q};
	assign div_ge    = (div_shift >= {1'b0, count_q});
	assign rem_nxt   = div_ge ? div_sub[CNT_W-1:0] : div_shift[CNT_W-1:0];
	assign quo_nxt   = {dvd_q[SQ_W-2:0], div_ge};
	assign div_last  = (div_cnt_q == DCNT_W'(1));

	assign issue_last = ((CNT_W'(addr_q) + CNT_W'(1)) == count_q);
	assign sq_drained = !issue_q && !v_s1 && !v_s2;
	assign dev = (rd_s1 >= mean_q) ? rd_s1 - mean_q : mean_q - rd_s1;

	assign trial     = root_q + bit_q;
	assign sqrt_ge   = (sqv_q >= trial);
	assign sqv_nxt   = sqrt_ge ? sqv_q - trial : sqv_q;
	assign root_nxt  = sqrt_ge ? (root_q >> 1) + bit_q : root_q >> 1;
	assign sqrt_last = bit_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			sum_q     <= '0;
			drop_q    <= 1'b0;
			div_cnt_q <= '0;
			addr_q    <= '0;
			issue_q   <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= issue_q;
			v_s2   <= v_s1;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sum_q <= sum_nxt;
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
						if (item.is_last) begin
							div_cnt_q <= DCNT_W'(SQ_W);
							state_q   <= S_DIV_MEAN;
						end
					end
				end
				S_DIV_MEAN: begin
					div_cnt_q <= div_cnt_q - DCNT_W'(1);
					if (div_last) begin
						addr_q  <= '0;
						issue_q <= 1'b1;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (issue_q) begin
						if (issue_last) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + ADDR_W'(1);
						end
					end
					if (sq_drained) begin
						div_cnt_q <= DCNT_W'(SQ_W);
						state_q   <= S_DIV_VAR;
					end
				end
				S_DIV_VAR: begin
					div_cnt_q <= div_cnt_q - DCNT_W'(1);
					if (div_last) begin
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sqrt_last) begin
						done_q  <= 1'b1;
						count_q <= '0;
						sum_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[count_q[ADDR_W-1:0]] <= item.sample;
		end
		if (issue_q) begin
			rd_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= VAR_W'(dev) * VAR_W'(dev);
		case (state_q)
			S_IDLE: begin
				if (accept && item.is_last) begin
					dvd_q <= SQ_W'(sum_nxt);
					rem_q <= '0;
				end
			end
			S_DIV_MEAN: begin
				dvd_q <= quo_nxt;
				rem_q <= rem_nxt;
				acc_q <= '0;
				if (div_last) begin
					mean_q <= quo_nxt[SAMPLE_BITS-1:0];
				end
			end
			S_SQ: begin
				if (v_s2) begin
					acc_q <= acc_q + SQ_W'(prod_s2);
				end
				dvd_q <= acc_q;
				rem_q <= '0;
			end
			S_DIV_VAR: begin
				dvd_q <= quo_nxt;
				rem_q <= rem_nxt;
				if (div_last) begin
					var_q  <= quo_nxt[VAR_W-1:0];
					sqv_q  <= quo_nxt[VAR_W-1:0];
					root_q <= '0;
					bit_q  <= SQRT_BIT0;
				end
			end
			S_SQRT: begin
				sqv_q  <= sqv_nxt;
				root_q <= root_nxt;
				bit_q  <= bit_q >> 2;
				if (sqrt_last) begin
					result_q.mean         <= mean_q;
					result_q.variance     <= var_q;
					result_q.std_dev      <= root_nxt[SAMPLE_BITS-1:0];
					result_q.sample_count <= count_q;
					result_q.overflow     <= drop_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond buffer capacity");
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (result_q.sample_count != '0))
		else $error("result with zero samples");
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.is_last) |=> busy)
		else $error("last sample did not start the passes");
	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> $past(v_s1))
		else $error("square pipeline valid out of order");
`endif

endmodule

@@ test/mvs_checker.sv @@
// Checker for mean_variance_stddev_unit: watches the sample and result channels,
// predicts the statistics of each closed set and compares them field by field.
// Depends on mvs_pkg for sizing constants and the beat structs.
module mvs_checker
	import mvs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  mvs_in_t  item,
	input  logic     done,
	input  mvs_out_t result,
	output int       failures,
	output int       results_due,
	output int       results_seen
);

	logic [SAMPLE_BITS-1:0] set_samples [MAX_SAMPLES];
	int unsigned            held;
	longint unsigned        held_sum;
	logic                   dropped;
	mvs_out_t               stats_due [$];
	mvs_out_t               want;

	function automatic logic [SAMPLE_BITS-1:0] floor_root(input longint unsigned v);
		longint unsigned r;
		longint unsigned trial;
		r = 0;
		for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v)
				r = trial;
		end
		return r[SAMPLE_BITS-1:0];
	endfunction

	// deviations are taken from the already floored mean
	function automatic mvs_out_t summarize_set();
		mvs_out_t        s;
		longint unsigned avg;
		longint unsigned smp;
		longint unsigned dev;
		longint unsigned sq_sum;
		longint unsigned var_q;
		avg = held_sum / 64'(held);
		sq_sum = 0;
		for (int unsigned i = 0; i < held; i++) begin
			smp = 64'(set_samples[ADDR_W'(i)]);
			dev = (smp >= avg) ? smp - avg : avg - smp;
			sq_sum += dev * dev;
		end
		var_q = sq_sum / 64'(held);
		s.mean         = avg[SAMPLE_BITS-1:0];
		s.variance     = var_q[VAR_W-1:0];
		s.std_dev      = floor_root(var_q);
		s.sample_count = held[CNT_W-1:0];
		s.overflow     = dropped;
		return s;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			held_sum = 0;
			dropped = 1'b0;
			stats_due.delete();
			failures = 0;
			results_seen = 0;
		end else begin
			// result first: a beat accepted on this edge cannot finish on it
			if (done) begin
				results_seen++;
				if (stats_due.size() == 0) begin
					$error("result beat with no expectation pending");
					failures++;
				end else begin
					want = stats_due.pop_front();
					check_field("mean", 32'(want.mean), 32'(result.mean));
					check_field("variance", 32'(want.variance), 32'(result.variance));
					check_field("std_dev", 32'(want.std_dev), 32'(result.std_dev));
					check_field("sample_count", 32'(want.sample_count),
						32'(result.sample_count));
					check_field("overflow", 32'(want.overflow), 32'(result.overflow));
				end
			end
			if (start && !busy) begin
				if (held < MAX_SAMPLES) begin
					set_samples[held[ADDR_W-1:0]] = item.sample;
					held++;
					held_sum += 64'(item.sample);
				end else begin
					dropped = 1'b1;
				end
				if (item.is_last) begin
					stats_due.push_back(summarize_set());
					held = 0;
					held_sum = 0;
					dropped = 1'b0;
				end
			end
		end
		results_due = stats_due.size();
	end

endmodule

@@ test/tb_mean_variance_stddev_unit.sv @@
// Testbench top for mean_variance_stddev_unit: drives sample sets in random bursts
// and gives the verdict. Depends on mvs_pkg, the unit itself and mvs_checker.
module tb_mean_variance_stddev_unit;
	import mvs_pkg::*;

	localparam int RANDOM_ITEMS = 1250;
	localparam int DRAIN_CYCLES = MAX_SAMPLES + 100;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam logic [SAMPLE_BITS-1:0] TOP_SAMPLE = '1;

	typedef enum int {FILL_ANY, FILL_LOW, FILL_FLAT, FILL_EXTREME, FILL_NARROW} fill_t;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	mvs_in_t  item;
	mvs_out_t result;

	int failures;
	int results_due;
	int results_seen;
	int beats_sent = 0;
	int sets_sent = 0;
	int full_sets = 0;
	int burst_left = 0;
	int cycle_count = 0;
	logic [SAMPLE_BITS-1:0] fill_base;

	mean_variance_stddev_unit dut (
		.clk,
		.arst_n,
		.start,
		.item,
		.busy,
		.done,
		.result
	);

	mvs_checker stats_check (
		.clk,
		.arst_n,
		.start,
		.busy,
		.item,
		.done,
		.result,
		.failures,
		.results_due,
		.results_seen
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [SAMPLE_BITS-1:0] pick_value(input fill_t fill);
		case (fill)
			FILL_LOW:     return SAMPLE_BITS'($urandom_range(0, 15));
			FILL_FLAT:    return fill_base;
			FILL_EXTREME: return $urandom_range(0, 1) ? TOP_SAMPLE : '0;
			FILL_NARROW:  return fill_base + SAMPLE_BITS'($urandom_range(0, 3));
			default:      return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
		endcase
	endfunction

	// bursts of random length; an occasional long one runs with no gaps
	task automatic send_beat(input logic [SAMPLE_BITS-1:0] v, input logic lst);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start <= 1'b1;
		item <= '{sample: v, is_last: lst};
		do @(posedge clk); while (busy);
		@(negedge clk);
		burst_left--;
		beats_sent++;
		if (lst)
			sets_sent++;
	endtask

	task automatic send_set(input int len, input fill_t fill);
		fill_base = SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 4));
		for (int i = 0; i < len; i++)
			send_beat(pick_value(fill), i == len - 1);
		if (len > MAX_SAMPLES)
			full_sets++;
	endtask

	task automatic settle();
		start <= 1'b0;
		wait (results_due == 0);
		@(negedge clk);
	endtask

	initial begin
		int first_random;
		int pick;
		int len;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_beat('0, 1'b1);
		send_beat(TOP_SAMPLE, 1'b1);
		send_beat('0, 1'b0);
		send_beat(TOP_SAMPLE, 1'b1);
		repeat (2) send_beat(TOP_SAMPLE, 1'b0);
		send_beat(TOP_SAMPLE, 1'b1);
		for (int v = 1; v <= 4; v++)
			send_beat(SAMPLE_BITS'(v), v == 4);
		send_beat(13'h1555, 1'b0);
		send_beat(13'h0AAA, 1'b1);
		repeat (3) send_beat('0, 1'b0);
		send_beat(TOP_SAMPLE, 1'b1);
		settle();

		// exactly full, then one past capacity with the last beat dropped
		first_random = beats_sent;
		send_set(MAX_SAMPLES, FILL_ANY);
		send_set(MAX_SAMPLES + 1, FILL_EXTREME);
		while (beats_sent - first_random < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			len = (pick < 2) ? $urandom_range(MAX_SAMPLES - 20, MAX_SAMPLES + 40)
				: $urandom_range(1, 12);
			send_set(len, fill_t'($urandom_range(0, 4)));
			if ($urandom_range(0, 9) == 0)
				settle();
		end

		start <= 1'b0;
		wait (results_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d sample beats in %0d sets, %0d of them beyond buffer capacity.",
			beats_sent, sets_sent, full_sets);
		$display("Checked %0d result beats against predicted mean, variance and root.",
			results_seen);
		if (failures == 0 && results_due == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
